// File: sv/assert_macros.svh
// Assertion macros shared by the RTL of the JSON string unescaper.
// Simulation builds get concurrent assertions; synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: sv/jsu_pkg.sv
// Package for the JSON string unescaper: types, character codes and helpers.
// Used by jsu_front, jsu_queue, jsu_back and the top level; depends on nothing.
`timescale 1ns / 1ps

package jsu_pkg;

	// Sizes.
	localparam int MAX_CAPACITY_DEF = 4096;
	localparam int CAPACITY_RESET   = 4096;
	localparam int CAP_W            = 13;
	localparam int LEN_W            = 12;
	localparam int NBYTES           = 6;
	localparam int IDX_W            = 3;
	localparam int QDEPTH           = 4;
	localparam int QPTR_W           = 2;

	// Character codes.
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_DIG0   = 8'h30;
	localparam logic [7:0] CH_DIG9   = 8'h39;
	localparam logic [7:0] CH_LOW_A  = 8'h61;
	localparam logic [7:0] CH_LOW_F  = 8'h66;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_F   = 8'h46;

	// UTF-8 encoding constants.
	localparam logic [7:0]  UTF8_LEAD2     = 8'hC0;
	localparam logic [7:0]  UTF8_LEAD3     = 8'hE0;
	localparam logic [7:0]  UTF8_CONT      = 8'h80;
	localparam logic [7:0]  UTF8_MASK6     = 8'h3F;
	localparam logic [15:0] UTF8_TWO_MIN   = 16'h0080;
	localparam logic [15:0] UTF8_THREE_MIN = 16'h0800;

	// Escape decoder state.
	typedef enum logic [2:0] {
		MODE_NORMAL = 3'd0,
		MODE_ESC    = 3'd1,
		MODE_HEX0   = 3'd2,
		MODE_HEX1   = 3'd3,
		MODE_HEX2   = 3'd4,
		MODE_HEX3   = 3'd5
	} mode_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic [7:0]       out_byte;
		logic             is_end;
		logic [LEN_W-1:0] out_length;
	} out_item_t;

	// One queued command: bytes to emit in order, and whether they form one
	// code that must fit whole, and whether the string ends after them.
	typedef struct packed {
		logic [NBYTES-1:0][7:0] bytes;
		logic [IDX_W-1:0]       count;
		logic                   atomic;
		logic                   is_end;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	// Returns {is_hex, value} for one byte.
	function automatic logic [4:0] hex_decode(input logic [7:0] b);
		logic [4:0] r;
		r = '0;
		if (b inside {[CH_DIG0:CH_DIG9]}) begin
			r = {1'b1, 4'(b - CH_DIG0)};
		end else if (b inside {[CH_LOW_A:CH_LOW_F]}) begin
			r = {1'b1, 4'(b - CH_LOW_A + 8'd10)};
		end else if (b inside {[CH_UP_A:CH_UP_F]}) begin
			r = {1'b1, 4'(b - CH_UP_A + 8'd10)};
		end
		return r;
	endfunction

endpackage

// File: sv/json_string_unescape_utf8_unit.sv
// Top level of the JSON string unescaper with UTF-8 output.
// Instantiates jsu_front, jsu_queue and jsu_back; depends on jsu_pkg and assert_macros.svh.
//
// Usage:
// - Input channel (byte_valid, byte_stall, byte_item) takes one raw byte of a JSON
//   string body per transaction; byte_item.last marks the final byte of a string.
// - Result channel (res_valid, res_stall, res_item) gives the decoded bytes, then one
//   closing transaction with is_end set and out_length holding the decoded length.
// - cfg_we/cfg_wdata write the capacity; at most capacity-1 bytes leave per string.
// - Path: a taken byte's command, if any, goes to a queue slot, and its first result is then
//   loaded into the result register when the queue ahead of it is empty and that register is free.
// - Throughput: one input byte per cycle while each byte yields one result and the
//   queue has room. A byte that yields several results keeps the playback unit busy
//   while they leave, as do a dropped UTF-8 code and a closing transaction; the
//   four-entry command queue absorbs such bursts and the input stalls only when it fills.
// - When res_stall is high and a result waits, the result register holds that
//   transaction, playback pauses, and input is still taken until the queue is full.
// - Reset clears the escape state, the queue, the counters and the result valid flag,
//   and sets the capacity to 4096, or to MAX_CAPACITY if that is smaller.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module json_string_unescape_utf8_unit #(
	parameter int MAX_CAPACITY = jsu_pkg::MAX_CAPACITY_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         byte_valid,
	output logic                         byte_stall,
	input  jsu_pkg::in_item_t            byte_item,
	output logic                         res_valid,
	input  logic                         res_stall,
	output jsu_pkg::out_item_t           res_item,
	input  logic                         cfg_we,
	input  logic [jsu_pkg::CAP_W-1:0]    cfg_wdata
);
	import jsu_pkg::*;

	localparam int CNT_W     = $clog2(MAX_CAPACITY);
	localparam int LIM_RESET = (CAPACITY_RESET > MAX_CAPACITY) ?
		(MAX_CAPACITY - 1) : (CAPACITY_RESET - 1);

	logic             push, pop;
	q_entry_t         entry, head;
	fifo_stat_t       q_stat;
	logic [CNT_W-1:0] lim_q, lim_wr;

	// Capacity is kept as the clamped byte limit.
	always_comb begin
		if (32'(cfg_wdata) > MAX_CAPACITY) begin
			lim_wr = CNT_W'(MAX_CAPACITY - 1);
		end else if (cfg_wdata == '0) begin
			lim_wr = '0;
		end else begin
			lim_wr = CNT_W'(cfg_wdata - 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= CNT_W'(LIM_RESET);
		end else if (cfg_we) begin
			lim_q <= lim_wr;
		end
	end

	// Escape decoding.
	jsu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item),
		.q_stat     (q_stat),
		.push       (push),
		.entry      (entry)
	);

	// Command queue.
	jsu_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.entry_in (entry),
		.pop      (pop),
		.head     (head),
		.stat     (q_stat)
	);

	// Byte playback and length tracking.
	jsu_back #(
		.MAX_CAPACITY (MAX_CAPACITY)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.limit     (lim_q),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

	// Queue and result checks.
	`ASSERT_IMPL(a_no_push_when_full, clk, arst_n, push, !q_stat.full)
	`ASSERT_IMPL(a_no_pop_when_empty, clk, arst_n, pop, !q_stat.empty)
	`ASSERT_NEXT(a_head_kept, clk, arst_n, !q_stat.empty && !pop, !q_stat.empty)
	`ASSERT_IMPL(a_len_only_on_end, clk, arst_n, res_valid && !res_item.is_end,
		res_item.out_length == '0)

endmodule

// File: sv/jsu_front.sv
// Front end of the JSON string unescaper: accepts raw bytes, tracks escape state
// and turns each byte into a queue command. Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_stall,
	input  jsu_pkg::in_item_t    byte_item,
	input  jsu_pkg::fifo_stat_t  q_stat,
	output logic                 push,
	output jsu_pkg::q_entry_t    entry
);
	import jsu_pkg::*;

	mode_t            mode_q, mode_n;
	logic [11:0]      accum_q, accum_n;
	logic [2:0][7:0]  raw_q, raw_n, rawx;
	logic             accept;
	logic [7:0]       b;
	logic             last;
	logic [4:0]       hex;
	logic             is_hex;
	logic [3:0]       dval;
	logic [1:0]       k;
	logic [15:0]      cp;
	logic             do_flush, do_plain;
	logic [2:0][7:0]  fl_raw;
	logic [IDX_W-1:0] fl_n, pos;

	assign b      = byte_item.in_byte;
	assign last   = byte_item.last;
	assign hex    = hex_decode(b);
	assign is_hex = hex[4];
	assign dval   = hex[3:0];
	assign cp     = {accum_q, dval};

	// A transaction is taken whenever the queue has room.
	assign byte_stall = q_stat.full;
	assign accept     = byte_valid && !q_stat.full;
	assign push       = accept && (entry.count != '0 || entry.is_end);

	// Number of hex digits already taken.
	always_comb begin
		case (mode_q)
			MODE_HEX1: k = 2'd1;
			MODE_HEX2: k = 2'd2;
			MODE_HEX3: k = 2'd3;
			default:   k = 2'd0;
		endcase
	end

	// Raw digit bytes with the current byte appended.
	always_comb begin
		rawx = raw_q;
		if (k != 2'd3) begin
			rawx[k] = b;
		end
	end

	// Next state.
	always_comb begin
		mode_n  = mode_q;
		accum_n = accum_q;
		raw_n   = raw_q;
		if (accept) begin
			if (last) begin
				mode_n  = MODE_NORMAL;
				accum_n = '0;
				raw_n   = '0;
			end else begin
				case (mode_q)
					MODE_ESC: begin
						if (b == CH_U) begin
							mode_n  = MODE_HEX0;
							accum_n = '0;
							raw_n   = '0;
						end else begin
							mode_n = MODE_NORMAL;
						end
					end
					MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
						if (is_hex) begin
							accum_n = {accum_q[7:0], dval};
							raw_n   = rawx;
							case (mode_q)
								MODE_HEX0: mode_n = MODE_HEX1;
								MODE_HEX1: mode_n = MODE_HEX2;
								MODE_HEX2: mode_n = MODE_HEX3;
								default:   mode_n = MODE_NORMAL;
							endcase
						end else if (b == CH_BSLASH) begin
							mode_n = MODE_ESC;
						end else begin
							mode_n = MODE_NORMAL;
						end
					end
					default: begin
						mode_n = (b == CH_BSLASH) ? MODE_ESC : MODE_NORMAL;
					end
				endcase
			end
		end
	end

	// Command for the current byte.
	always_comb begin
		entry        = '0;
		entry.is_end = last;
		do_flush     = 1'b0;
		do_plain     = 1'b0;
		fl_raw       = raw_q;
		fl_n         = '0;
		pos          = '0;
		case (mode_q)
			MODE_ESC: begin
				entry.count = 3'd1;
				case (b)
					CH_QUOTE, CH_BSLASH, CH_SLASH: entry.bytes[0] = b;
					CH_B: entry.bytes[0] = CH_BS;
					CH_F: entry.bytes[0] = CH_FF;
					CH_N: entry.bytes[0] = CH_LF;
					CH_R: entry.bytes[0] = CH_CR;
					CH_T: entry.bytes[0] = CH_TAB;
					CH_U: begin
						// A bare \u at the end of the string is copied.
						if (last) begin
							do_flush = 1'b1;
						end else begin
							entry.count = '0;
						end
					end
					default: begin
						entry.bytes[0] = CH_BSLASH;
						entry.bytes[1] = b;
						entry.count    = 3'd2;
					end
				endcase
			end
			MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
				if (is_hex) begin
					if (mode_q == MODE_HEX3) begin
						// Fourth digit: one code point as 1 to 3 UTF-8 bytes.
						entry.atomic = 1'b1;
						if (cp < UTF8_TWO_MIN) begin
							entry.count    = 3'd1;
							entry.bytes[0] = cp[7:0];
						end else if (cp < UTF8_THREE_MIN) begin
							entry.count    = 3'd2;
							entry.bytes[0] = UTF8_LEAD2 | {3'b000, cp[10:6]};
							entry.bytes[1] = UTF8_CONT | ({2'b00, cp[5:0]} & UTF8_MASK6);
						end else begin
							entry.count    = 3'd3;
							entry.bytes[0] = UTF8_LEAD3 | {4'b0000, cp[15:12]};
							entry.bytes[1] = UTF8_CONT | ({2'b00, cp[11:6]} & UTF8_MASK6);
							entry.bytes[2] = UTF8_CONT | ({2'b00, cp[5:0]} & UTF8_MASK6);
						end
					end else if (last) begin
						// String ends inside a short escape.
						do_flush = 1'b1;
						fl_raw   = rawx;
						fl_n     = 3'({1'b0, k} + 3'd1);
					end
				end else begin
					// Bad escape: replay it, then take the byte as plain text.
					do_flush = 1'b1;
					fl_n     = 3'(k);
					do_plain = 1'b1;
				end
			end
			default: do_plain = 1'b1;
		endcase

		if (do_flush) begin
			entry.bytes[0] = CH_BSLASH;
			entry.bytes[1] = CH_U;
			for (int j = 0; j < 3; j++) begin
				if (3'(j) < fl_n) begin
					entry.bytes[2 + j] = fl_raw[j];
				end
			end
			pos = 3'd2 + fl_n;
		end
		if (do_plain && !(b == CH_BSLASH && !last)) begin
			entry.bytes[pos] = b;
			pos = pos + 3'd1;
		end
		if (do_flush || do_plain) begin
			entry.count = pos;
		end
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_NORMAL;
			accum_q <= '0;
			raw_q   <= '0;
		end else begin
			mode_q  <= mode_n;
			accum_q <= accum_n;
			raw_q   <= raw_n;
		end
	end

endmodule

// File: sv/jsu_queue.sv
// Command queue between the front and back ends of the JSON string unescaper.
// A small register FIFO of q_entry_t commands. Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  jsu_pkg::q_entry_t    entry_in,
	input  logic                 pop,
	output jsu_pkg::q_entry_t    head,
	output jsu_pkg::fifo_stat_t  stat
);
	import jsu_pkg::*;

	q_entry_t          slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   fill_q;

	assign head       = slot_q[rd_ptr_q];
	assign stat.full  = (fill_q == (QPTR_W + 1)'(QDEPTH));
	assign stat.empty = (fill_q == '0);

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= entry_in;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// File: sv/jsu_back.sv
// JSON string unescaper back end: plays queued commands out one byte per cycle
// unless stalled, applies the output limit, closes strings. Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_back #(
	parameter int MAX_CAPACITY = jsu_pkg::MAX_CAPACITY_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  jsu_pkg::q_entry_t                 head,
	input  jsu_pkg::fifo_stat_t               q_stat,
	input  logic [$clog2(MAX_CAPACITY)-1:0]   limit,
	output logic                              pop,
	output logic                              res_valid,
	input  logic                              res_stall,
	output jsu_pkg::out_item_t                res_item
);
	import jsu_pkg::*;

	localparam int CNT_W = $clog2(MAX_CAPACITY);

	logic [IDX_W-1:0] idx_q, idx_n, idx_adv;
	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic             stopped_q, stopped_n;
	logic             res_valid_q;
	out_item_t        res_item_q, item_n;
	logic             out_free, step, in_bytes, code_start, fits, can1, emit_ok, load;
	logic [CNT_W:0]   cnt_inc;

	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

	// Room checks against the output limit.
	assign out_free   = !res_valid_q || !res_stall;
	assign step       = !q_stat.empty && out_free;
	assign in_bytes   = idx_q < head.count;
	assign code_start = head.atomic && (idx_q == '0);
	assign cnt_inc    = {1'b0, cnt_q} + 1'b1;
	assign fits       = !stopped_q &&
		(({1'b0, cnt_q} + (CNT_W + 1)'(head.count)) <= {1'b0, limit});
	assign can1       = !stopped_q && (cnt_q < limit);
	assign emit_ok    = code_start ? fits : can1;
	assign idx_adv    = (code_start && !fits) ? head.count : idx_q + 1'b1;

	// One step of the current command.
	always_comb begin
		idx_n     = idx_q;
		cnt_n     = cnt_q;
		stopped_n = stopped_q;
		pop       = 1'b0;
		load      = 1'b0;
		item_n    = '0;
		if (step) begin
			if (in_bytes) begin
				if (emit_ok) begin
					load            = 1'b1;
					item_n.out_byte = head.bytes[idx_q];
					cnt_n           = cnt_inc[CNT_W-1:0];
					stopped_n       = stopped_q || (cnt_inc >= {1'b0, limit});
				end else begin
					stopped_n = stopped_q || (cnt_q >= limit);
				end
				if (idx_adv == head.count && !head.is_end) begin
					pop   = 1'b1;
					idx_n = '0;
				end else begin
					idx_n = idx_adv;
				end
			end else begin
				// Closing transaction carries the length and clears the counters.
				load              = 1'b1;
				item_n.is_end     = 1'b1;
				item_n.out_length = LEN_W'(cnt_q);
				cnt_n             = '0;
				stopped_n         = 1'b0;
				pop               = 1'b1;
				idx_n             = '0;
			end
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			cnt_q       <= '0;
			stopped_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			idx_q     <= idx_n;
			cnt_q     <= cnt_n;
			stopped_q <= stopped_n;
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (load) begin
			res_item_q <= item_n;
		end
	end

endmodule
